>>> rtl/core/double_cal_pulse_time_reference_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double calibration pulse time reference block
// Concurrent assertion shorthands used by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_CAL_PULSE_TIME_REFERENCE_ASSERT_SVH
`define DOUBLE_CAL_PULSE_TIME_REFERENCE_ASSERT_SVH

// same-cycle implication
`define DCPTR_AST_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCPTR_AST_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dcptr_pkg.sv
// ----------------------------------------------------------------------------
// dcptr_pkg
// Types and constants of the double calibration pulse time reference block.
// ----------------------------------------------------------------------------
package dcptr_pkg;

  // hit counts up to 64 need 7 bits
  localparam int CNT_W = 7;

  // pulse gap limits, 50 and 90 bins with 4 fraction bits, both exclusive
  localparam logic [15:0] GAP_MIN_RAW = 16'd800;
  localparam logic [15:0] GAP_MAX_RAW = 16'd1440;

  // register reset values
  localparam logic [3:0]         CAL_CHANNEL_RST   = 4'd7;
  localparam logic [15:0]        TDC_WIN_LOW_RST   = 16'd0;
  localparam logic [15:0]        TDC_WIN_HIGH_RST  = 16'd32000;
  localparam logic [7:0]         WIDTH_LOW_RST     = 8'd21;
  localparam logic [7:0]         WIDTH_HIGH_RST    = 8'd48;
  localparam logic signed [12:0] ADC_THR_LOW_RST   = 13'sd400;
  localparam logic signed [12:0] ADC_THR_HIGH_RST  = 13'sd1000;

  typedef enum logic [2:0] {
    CFG_CAL_CHANNEL  = 3'd0,
    CFG_TDC_WIN_LOW  = 3'd1,
    CFG_TDC_WIN_HIGH = 3'd2,
    CFG_WIDTH_LOW    = 3'd3,
    CFG_WIDTH_HIGH   = 3'd4,
    CFG_ADC_THR_LOW  = 3'd5,
    CFG_ADC_THR_HIGH = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FLAG_NONE  = 2'd0,
    FLAG_CAL   = 2'd1,
    FLAG_LATE  = 2'd2,
    FLAG_EARLY = 2'd3
  } flag_t;

  // back part sequence
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN_LATE,
    BK_SCAN_EARLY,
    BK_EMIT_RD,
    BK_EMIT_WAIT
  } back_state_t;

  typedef logic [CNT_W-1:0] count_t;

  // input request, highest field first
  typedef struct packed {
    logic [2:0]         pad;
    logic signed [12:0] adc_height;
    logic [7:0]         pulse_width;
    logic [15:0]        tdc_bin;
    logic [3:0]         asic_channel;
    logic [3:0]         asic_number;
    logic [7:0]         board_id;
  } in_data_t;

  // result, highest field first
  typedef struct packed {
    logic [5:0]         pad;
    logic               overflow;
    flag_t              hit_flag;
    logic [15:0]        reference_time;
    logic signed [16:0] corrected_time;
    logic [5:0]         hit_index;
  } out_data_t;

  // one stored hit
  typedef struct packed {
    logic [15:0] tdc;
    logic [11:0] key;   // board_id, asic_number
    logic        cand;
  } hit_entry_t;

  // one finished event, handed from front to back
  typedef struct packed {
    logic   bank;
    count_t count;
    logic   overflow;
  } event_desc_t;

  // bank release from back to front
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

>>> rtl/core/dcptr_hit_ram.sv
// ----------------------------------------------------------------------------
// dcptr_hit_ram
// Two-bank hit buffer, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dcptr_hit_ram #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  dcptr_pkg::hit_entry_t      wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output dcptr_pkg::hit_entry_t      rd_data
);
  import dcptr_pkg::*;

  hit_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/dcptr_desc_fifo.sv
// ----------------------------------------------------------------------------
// dcptr_desc_fifo
// Two-entry queue of finished events between the front and back parts.
// ----------------------------------------------------------------------------
module dcptr_desc_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  dcptr_pkg::event_desc_t   push_desc,
  input  logic                     pop,
  output dcptr_pkg::event_desc_t   head,
  output logic                     empty,
  output logic                     full
);
  import dcptr_pkg::*;

  event_desc_t slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

>>> rtl/core/dcptr_front.sv
// ----------------------------------------------------------------------------
// dcptr_front
// Holds the configuration, accepts hits, marks candidates and fills the
// current buffer bank; on the last hit it hands the event to the back part.
// ----------------------------------------------------------------------------
module dcptr_front #(
  parameter int MAX_HITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  dcptr_pkg::in_data_t            s_tdata,
  input  logic                           s_tlast,
  output logic                           wr_en,
  output logic [$clog2(MAX_HITS):0]      wr_addr,
  output dcptr_pkg::hit_entry_t          wr_data,
  output logic                           push,
  output dcptr_pkg::event_desc_t         push_desc,
  input  logic                           fifo_full,
  input  dcptr_pkg::bank_rel_t           rel
);
  import dcptr_pkg::*;

  localparam int IW = $clog2(MAX_HITS);
  localparam count_t MAX_CNT = count_t'(MAX_HITS);

  logic [3:0]         cal_channel;
  logic [15:0]        tdc_window_low;
  logic [15:0]        tdc_window_high;
  logic [7:0]         width_low;
  logic [7:0]         width_high;
  logic signed [12:0] adc_threshold_low;
  logic signed [12:0] adc_threshold_high;

  logic       bank;
  logic [1:0] busy;
  count_t     hit_count;
  logic       overflow_seen;
  logic       accept;
  logic       room;
  logic       cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_channel        <= CAL_CHANNEL_RST;
      tdc_window_low     <= TDC_WIN_LOW_RST;
      tdc_window_high    <= TDC_WIN_HIGH_RST;
      width_low          <= WIDTH_LOW_RST;
      width_high         <= WIDTH_HIGH_RST;
      adc_threshold_low  <= ADC_THR_LOW_RST;
      adc_threshold_high <= ADC_THR_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAL_CHANNEL:  cal_channel        <= cfg_wdata[3:0];
        CFG_TDC_WIN_LOW:  tdc_window_low     <= cfg_wdata;
        CFG_TDC_WIN_HIGH: tdc_window_high    <= cfg_wdata;
        CFG_WIDTH_LOW:    width_low          <= cfg_wdata[7:0];
        CFG_WIDTH_HIGH:   width_high         <= cfg_wdata[7:0];
        CFG_ADC_THR_LOW:  adc_threshold_low  <= cfg_wdata[12:0];
        CFG_ADC_THR_HIGH: adc_threshold_high <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // a bank is reused only after the back part has emitted it
  assign s_tready = !busy[bank] && !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign room     = (hit_count < MAX_CNT);

  assign cand = adc_threshold_low[12] &&
                (s_tdata.tdc_bin > tdc_window_low) &&
                (s_tdata.tdc_bin < tdc_window_high) &&
                (s_tdata.pulse_width > width_low) &&
                (s_tdata.pulse_width < width_high) &&
                (s_tdata.adc_height < adc_threshold_low) &&
                (s_tdata.adc_height > adc_threshold_high) &&
                (s_tdata.asic_channel == cal_channel);

  assign wr_en        = accept && room;
  assign wr_addr      = {bank, hit_count[IW-1:0]};
  assign wr_data.tdc  = s_tdata.tdc_bin;
  assign wr_data.key  = {s_tdata.board_id, s_tdata.asic_number};
  assign wr_data.cand = cand;

  assign push               = accept && s_tlast;
  assign push_desc.bank     = bank;
  assign push_desc.count    = room ? hit_count + count_t'(1) : hit_count;
  assign push_desc.overflow = overflow_seen || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank          <= 1'b0;
      busy          <= 2'b00;
      hit_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (rel.en) begin
        busy[rel.bank] <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          busy[bank]    <= 1'b1;
          bank          <= ~bank;
          hit_count     <= '0;
          overflow_seen <= 1'b0;
        end else if (room) begin
          hit_count <= hit_count + count_t'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/dcptr_back.sv
// ----------------------------------------------------------------------------
// dcptr_back
// Per event: scan for the late pulse, scan for its partner, then emit every
// stored hit with its corrected time through an output register.
// ----------------------------------------------------------------------------
module dcptr_back #(
  parameter int MAX_HITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dcptr_pkg::event_desc_t         head,
  input  logic                           fifo_empty,
  output logic                           pop,
  output logic                           rd_en,
  output logic [$clog2(MAX_HITS):0]      rd_addr,
  input  dcptr_pkg::hit_entry_t          rd_data,
  output dcptr_pkg::bank_rel_t           rel,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output dcptr_pkg::out_data_t           m_tdata,
  output logic                           m_tlast
);
  import dcptr_pkg::*;

  localparam int IW = $clog2(MAX_HITS);

  back_state_t state, state_next;

  event_desc_t   evt;
  count_t        iss;
  logic          rd_vld;
  logic          rd_last;
  logic [IW-1:0] rd_idx;

  logic          have_late;
  logic [IW-1:0] late_idx;
  logic [15:0]   late_tdc;
  logic [11:0]   late_key;
  logic          have_early;
  logic [IW-1:0] early_idx;

  logic          load_out;
  logic [15:0]   gap;
  logic [15:0]   ref_val;
  flag_t         flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    rel.en     = 1'b0;
    rel.bank   = evt.bank;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          pop        = 1'b1;
          state_next = BK_SCAN_LATE;
        end
      end
      BK_SCAN_LATE: begin
        rd_en = (iss < evt.count);
        if (rd_vld && rd_last) begin
          state_next = BK_SCAN_EARLY;
        end
      end
      BK_SCAN_EARLY: begin
        rd_en = (iss < evt.count);
        if (rd_vld && rd_last) begin
          state_next = BK_EMIT_RD;
        end
      end
      BK_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = BK_EMIT_WAIT;
      end
      BK_EMIT_WAIT: begin
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if (rd_last) begin
            rel.en     = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_EMIT_RD;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign rd_addr = {evt.bank, iss[IW-1:0]};
  assign gap     = late_tdc - rd_data.tdc;

  // read pointer and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      iss        <= '0;
      rd_vld     <= 1'b0;
      rd_last    <= 1'b0;
      have_late  <= 1'b0;
      have_early <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (pop) begin
        iss        <= '0;
        have_late  <= 1'b0;
        have_early <= 1'b0;
      end else if (rd_en) begin
        iss     <= iss + count_t'(1);
        rd_last <= (iss == evt.count - count_t'(1));
      end else if (rd_vld && rd_last &&
                   (state == BK_SCAN_LATE || state == BK_SCAN_EARLY)) begin
        iss <= '0;
      end
      if (state == BK_SCAN_LATE && rd_vld && rd_data.cand &&
          (!have_late || rd_data.tdc > late_tdc)) begin
        have_late <= 1'b1;
      end
      if (state == BK_SCAN_EARLY && rd_vld && have_late && rd_data.cand &&
          (rd_data.tdc < late_tdc) && (gap > GAP_MIN_RAW) && (gap < GAP_MAX_RAW)) begin
        have_early <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      evt <= head;
    end
    if (rd_en) begin
      rd_idx <= iss[IW-1:0];
    end
    if (state == BK_SCAN_LATE && rd_vld && rd_data.cand &&
        (!have_late || rd_data.tdc > late_tdc)) begin
      late_idx <= rd_idx;
      late_tdc <= rd_data.tdc;
      late_key <= rd_data.key;
    end
    if (state == BK_SCAN_EARLY && rd_vld && have_late && rd_data.cand &&
        (rd_data.tdc < late_tdc) && (gap > GAP_MIN_RAW) && (gap < GAP_MAX_RAW)) begin
      early_idx <= rd_idx;
    end
  end

  // the reference is the late pulse's time for hits with its board and ASIC once a partner exists, else zero
  always_comb begin
    ref_val = (have_early && rd_data.key == late_key) ? late_tdc : 16'd0;
    if (ref_val == 16'd0) begin
      flag = FLAG_NONE;
    end else if (rd_idx == late_idx) begin
      flag = FLAG_LATE;
    end else if (rd_idx == early_idx) begin
      flag = FLAG_EARLY;
    end else begin
      flag = FLAG_CAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata.pad            <= '0;
      m_tdata.overflow       <= evt.overflow;
      m_tdata.hit_flag       <= flag;
      m_tdata.reference_time <= ref_val;
      m_tdata.corrected_time <= $signed({1'b0, rd_data.tdc}) - $signed({1'b0, ref_val});
      m_tdata.hit_index      <= 6'(rd_idx);
      m_tlast                <= rd_last;
    end
  end

endmodule

>>> rtl/core/double_cal_pulse_time_reference.sv
// ----------------------------------------------------------------------------
// double_cal_pulse_time_reference
// Hits of an event are loaded one per cycle, while the front is not stalled,
// into one of two buffer banks. After the request marked tlast, the back part
// takes the event from its queue, scans the bank for the latest calibration
// pulse, scans again for its partner more than 50 and less than 90 bins
// earlier, then emits each hit by reading its entry and then loading the
// output register. While one bank is being emitted the next event loads
// into the other; the front stalls only when both banks are taken.
// Hits past MAX_HITS are dropped and the event's results carry overflow.
// ----------------------------------------------------------------------------
module double_cal_pulse_time_reference #(
  parameter int MAX_HITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // board_id, asic_number, asic_channel, tdc_bin, pulse_width, adc_height
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit_index, corrected_time, reference_time, hit_flag, overflow
  output logic [47:0] m_tdata,
  output logic        m_tlast
);
  import dcptr_pkg::*;

  localparam int AW = $clog2(MAX_HITS) + 1;

  logic         wr_en;
  logic [AW-1:0] wr_addr;
  hit_entry_t   wr_data;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  hit_entry_t   rd_data;
  logic         push;
  event_desc_t  push_desc;
  logic         pop;
  event_desc_t  head;
  logic         fifo_empty;
  logic         fifo_full;
  bank_rel_t    rel;
  out_data_t    out_data;

  dcptr_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (in_data_t'(s_tdata)),
    .s_tlast   (s_tlast),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_desc (push_desc),
    .fifo_full (fifo_full),
    .rel       (rel)
  );

  // bank bit sits above the hit index, so each bank spans a power of two
  dcptr_hit_ram #(.DEPTH(2 ** AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dcptr_desc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  dcptr_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (out_data),
    .m_tlast    (m_tlast)
  );

  assign m_tdata = out_data;

endmodule

>>> rtl/core/dcptr_checker.sv
// ----------------------------------------------------------------------------
// dcptr_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_cal_pulse_time_reference_assert.svh"

module dcptr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  import dcptr_pkg::*;

  out_data_t res;
  logic      flag_none;

  assign res       = out_data_t'(m_tdata);
  assign flag_none = (res.hit_flag == FLAG_NONE);

  `DCPTR_AST_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
  `DCPTR_AST_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid, "result valid after reset")
  `DCPTR_AST_SAME(a_flag_ref, clk, rst, m_tvalid, flag_none == (res.reference_time == 16'd0), "flag and reference disagree")
  `DCPTR_AST_SAME(a_uncal_time, clk, rst, m_tvalid && flag_none, !res.corrected_time[16], "uncalibrated hit has negative time")

endmodule

bind double_cal_pulse_time_reference dcptr_checker u_checker (.*);

>>> tb/sv/dcptr_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcptr_result_checker
// Watches the register port and both stream channels of the double
// calibration pulse time reference block. It keeps its own copy of the
// registers and of the hit buffer, works out the results of every finished
// event, and compares each result that leaves the block, field by field.
// ----------------------------------------------------------------------------
module dcptr_result_checker #(
  parameter int MAX_HITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          event_count,
  output int          result_count,
  output int          ref_count,
  output int          ovf_count
);
  import dcptr_pkg::*;

  typedef struct {
    logic [5:0]         hit_index;
    logic signed [16:0] corrected_time;
    logic [15:0]        reference_time;
    flag_t              hit_flag;
    logic               overflow;
    logic               last_result;
  } hit_result_t;

  // register copy
  logic [3:0]         cal_channel_q;
  logic [15:0]        tdc_lo_q;
  logic [15:0]        tdc_hi_q;
  logic [7:0]         wid_lo_q;
  logic [7:0]         wid_hi_q;
  logic signed [12:0] adc_lo_q;
  logic signed [12:0] adc_hi_q;

  // hit buffer copy
  logic [15:0] tdc_buf [MAX_HITS];
  logic [11:0] key_buf [MAX_HITS];
  logic        cand_buf[MAX_HITS];
  int unsigned stored;
  logic        dropped;

  hit_result_t pending_results[$];
  in_data_t    hit;

  function automatic logic is_cal_candidate(in_data_t h);
    return adc_lo_q[12] &&
           (h.tdc_bin > tdc_lo_q) && (h.tdc_bin < tdc_hi_q) &&
           (h.pulse_width > wid_lo_q) && (h.pulse_width < wid_hi_q) &&
           ($signed(h.adc_height) < adc_lo_q) && ($signed(h.adc_height) > adc_hi_q) &&
           (h.asic_channel == cal_channel_q);
  endfunction

  // late pulse search, partner search, then one result per stored hit
  task automatic resolve_event_times();
    int unsigned n;
    int unsigned cands;
    int unsigned late;
    int unsigned early;
    bit          have_late;
    bit          have_early;
    logic [15:0] gap;
    logic [15:0] rt;
    hit_result_t r;
    n = stored;
    cands = 0;
    late = 0;
    early = 0;
    have_late = 0;
    have_early = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (cand_buf[i]) begin
        cands++;
        if (!have_late || tdc_buf[i] > tdc_buf[late]) begin
          late = i;
          have_late = 1;
        end
      end
    end
    if (cands >= 2) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (cand_buf[i] && tdc_buf[i] < tdc_buf[late]) begin
          gap = tdc_buf[late] - tdc_buf[i];
          if (gap > GAP_MIN_RAW && gap < GAP_MAX_RAW) begin
            early = i;
            have_early = 1;
          end
        end
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      rt = (have_early && key_buf[i] == key_buf[late]) ? tdc_buf[late] : 16'd0;
      r.hit_index      = 6'(i);
      r.corrected_time = {1'b0, tdc_buf[i]} - {1'b0, rt};
      r.reference_time = rt;
      r.overflow       = dropped;
      r.last_result    = (i + 1 == n);
      if (rt == 16'd0)
        r.hit_flag = FLAG_NONE;
      else if (i == late)
        r.hit_flag = FLAG_LATE;
      else if (have_early && i == early)
        r.hit_flag = FLAG_EARLY;
      else
        r.hit_flag = FLAG_CAL;
      pending_results.insert(pending_results.size(), r);
    end
    event_count++;
    if (have_early) ref_count++;
    if (dropped) ovf_count++;
    stored = 0;
    dropped = 0;
  endtask

  task automatic check_result(out_data_t got, logic got_last);
    hit_result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      $error("unexpected result: hit_index %0d, no result pending", got.hit_index);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.hit_index !== want.hit_index) begin
      $error("hit_index: expected %0d, actual %0d", want.hit_index, got.hit_index);
      fail_count++;
    end
    if (got.corrected_time !== want.corrected_time) begin
      $error("corrected_time: expected %0d, actual %0d", want.corrected_time,
             $signed(got.corrected_time));
      fail_count++;
    end
    if (got.reference_time !== want.reference_time) begin
      $error("reference_time: expected %0d, actual %0d", want.reference_time,
             got.reference_time);
      fail_count++;
    end
    if (got.hit_flag !== want.hit_flag) begin
      $error("hit_flag: expected %0d, actual %0d", want.hit_flag, got.hit_flag);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
      fail_count++;
    end
    if (got_last !== want.last_result) begin
      $error("last_result: expected %0d, actual %0d", want.last_result, got_last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cal_channel_q = CAL_CHANNEL_RST;
      tdc_lo_q      = TDC_WIN_LOW_RST;
      tdc_hi_q      = TDC_WIN_HIGH_RST;
      wid_lo_q      = WIDTH_LOW_RST;
      wid_hi_q      = WIDTH_HIGH_RST;
      adc_lo_q      = ADC_THR_LOW_RST;
      adc_hi_q      = ADC_THR_HIGH_RST;
      stored        = 0;
      dropped       = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CAL_CHANNEL:  cal_channel_q = cfg_wdata[3:0];
          CFG_TDC_WIN_LOW:  tdc_lo_q      = cfg_wdata;
          CFG_TDC_WIN_HIGH: tdc_hi_q      = cfg_wdata;
          CFG_WIDTH_LOW:    wid_lo_q      = cfg_wdata[7:0];
          CFG_WIDTH_HIGH:   wid_hi_q      = cfg_wdata[7:0];
          CFG_ADC_THR_LOW:  adc_lo_q      = cfg_wdata[12:0];
          CFG_ADC_THR_HIGH: adc_hi_q      = cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        hit = in_data_t'(s_tdata);
        if (stored < MAX_HITS) begin
          tdc_buf[stored]  = hit.tdc_bin;
          key_buf[stored]  = {hit.board_id, hit.asic_number};
          cand_buf[stored] = is_cal_candidate(hit);
          stored++;
        end else begin
          dropped = 1;
        end
        if (s_tlast) resolve_event_times();
      end
      if (m_tvalid && m_tready) check_result(out_data_t'(m_tdata), m_tlast);
    end
    pending <= pending_results.size();
  end

endmodule

>>> tb/sv/tb_double_cal_pulse_time_reference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_cal_pulse_time_reference
// Drives events of hits into the block under several register settings,
// with directed events for the pulse-pair corner cases, random events that
// are mostly well-formed pulse pairs, overflowing events and a long output
// stall. The result checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_double_cal_pulse_time_reference;
  import dcptr_pkg::*;

  localparam int MAX_HITS      = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 800;

  typedef struct {
    logic [3:0] cal_channel;
    int         tdc_lo;
    int         tdc_hi;
    int         wid_lo;
    int         wid_hi;
    int         adc_lo;
    int         adc_hi;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;
  int event_count;
  int result_count;
  int ref_count;
  int ovf_count;

  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_req;
  int       items_sent;
  int       quiet_cycles;
  int       target;
  setting_t cur;

  double_cal_pulse_time_reference #(
    .MAX_HITS(MAX_HITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dcptr_result_checker #(
    .MAX_HITS(MAX_HITS)
  ) u_result_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .event_count (event_count),
    .result_count(result_count),
    .ref_count   (ref_count),
    .ovf_count   (ovf_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ends the run when neither channel moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic int pick_open(int lo, int hi);
    if (hi - lo < 2) return lo;
    return lo + 1 + int'($urandom_range(hi - lo - 2, 0));
  endfunction

  function automatic in_data_t mk_hit(logic [7:0] board, logic [3:0] asic, logic [3:0] chan,
                                      logic [15:0] tdc, logic [7:0] width,
                                      logic [12:0] adc);
    in_data_t h;
    h = '0;
    h.board_id     = board;
    h.asic_number  = asic;
    h.asic_channel = chan;
    h.tdc_bin      = tdc;
    h.pulse_width  = width;
    h.adc_height   = adc;
    return h;
  endfunction

  function automatic in_data_t noise_hit();
    return mk_hit(8'($urandom), 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom),
                  13'($urandom));
  endfunction

  // calibration-channel hit with width and height inside the current windows, where one exists; TDC as given
  function automatic in_data_t cal_hit(logic [7:0] board, logic [3:0] asic, int tdc);
    return mk_hit(board, asic, cur.cal_channel, 16'(tdc),
                  8'(pick_open(cur.wid_lo, cur.wid_hi)),
                  13'(pick_open(cur.adc_hi, cur.adc_lo)));
  endfunction

  function automatic logic [15:0] reg_value(setting_t s, cfg_idx_t idx);
    case (idx)
      CFG_CAL_CHANNEL:  return 16'(s.cal_channel);
      CFG_TDC_WIN_LOW:  return 16'(s.tdc_lo);
      CFG_TDC_WIN_HIGH: return 16'(s.tdc_hi);
      CFG_WIDTH_LOW:    return 16'(s.wid_lo);
      CFG_WIDTH_HIGH:   return 16'(s.wid_hi);
      CFG_ADC_THR_LOW:  return 16'(s.adc_lo);
      default:          return 16'(s.adc_hi);
    endcase
  endfunction

  task automatic send_hit(in_data_t h, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_event(in_data_t ev[$]);
    foreach (ev[i]) send_hit(ev[i], i == ev.size() - 1);
  endtask

  // wait until every result is out and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(setting_t s);
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= reg_value(s, idx);
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    cur = s;
  endtask

  // late pulse with a partner (or one at exactly 50 or 90 bins), plus hits that share its ASIC, ties and noise
  task automatic send_pair_event();
    in_data_t    ev[$];
    in_data_t    h;
    logic [7:0]  board;
    logic [3:0]  asic;
    int          gap;
    int          e_tdc;
    board = 8'($urandom);
    asic  = 4'($urandom);
    if ($urandom_range(9) == 0)
      gap = $urandom_range(1) ? 800 : 1440;
    else
      gap = $urandom_range(1439, 801);
    e_tdc = pick_open(cur.tdc_lo, cur.tdc_hi - gap);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(3))
        0: h = noise_hit();
        1: begin
          h = noise_hit();
          h.board_id    = board;
          h.asic_number = asic;
        end
        2: h = cal_hit(board, asic, pick_open(cur.tdc_lo, e_tdc + gap));
        default: h = cal_hit(board, asic, e_tdc + gap);
      endcase
      ev.insert(ev.size(), h);
    end
    // partner on another ASIC now and then
    if ($urandom_range(3) == 0)
      h = cal_hit(8'($urandom), 4'($urandom), e_tdc);
    else
      h = cal_hit(board, asic, e_tdc);
    ev.insert($urandom_range(ev.size()), h);
    ev.insert($urandom_range(ev.size()), cal_hit(board, asic, e_tdc + gap));
    send_event(ev);
  endtask

  task automatic send_random_event();
    in_data_t   ev[$];
    int         pick;
    int         t;
    logic [7:0] board;
    logic [3:0] asic;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_pair_event();
    end else if (pick < 88) begin
      repeat ($urandom_range(8, 1)) ev.insert(ev.size(), noise_hit());
      send_event(ev);
    end else begin
      // lone candidate, or a pair at an arbitrary distance
      board = 8'($urandom);
      asic  = 4'($urandom);
      t = pick_open(cur.tdc_lo, cur.tdc_hi);
      ev.insert(ev.size(), cal_hit(board, asic, t));
      if ($urandom_range(1))
        ev.insert(ev.size(), cal_hit(board, asic, t - int'($urandom_range(3000))));
      send_event(ev);
    end
  endtask

  task automatic send_big_event(int n);
    in_data_t ev[$];
    int       t;
    repeat (n - 2) ev.insert(ev.size(), noise_hit());
    t = pick_open(cur.tdc_lo + 1000, cur.tdc_hi);
    ev.insert($urandom_range(ev.size()), cal_hit(8'd3, 4'd9, t - 1000));
    ev.insert($urandom_range(ev.size()), cal_hit(8'd3, 4'd9, t));
    send_event(ev);
  endtask

  task automatic send_random_until(int count);
    target = items_sent + count;
    while (items_sent < target) send_random_event();
  endtask

  initial begin
    in_data_t ev[$];
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    items_sent    = 0;
    cur = '{CAL_CHANNEL_RST, int'(TDC_WIN_LOW_RST), int'(TDC_WIN_HIGH_RST),
            int'(WIDTH_LOW_RST), int'(WIDTH_HIGH_RST), int'(ADC_THR_LOW_RST),
            int'(ADC_THR_HIGH_RST)};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: search is off, field extremes
    ev = {mk_hit(8'd0, 4'd0, 4'd0, 16'd0, 8'd0, 13'h1000),
          mk_hit(8'd255, 4'd15, 4'd15, 16'hFFFF, 8'd255, 13'h0FFF),
          mk_hit(8'd1, 4'd1, 4'd7, 16'd1000, 8'd30, 13'd500)};
    send_event(ev);
    drain();

    apply_setting('{4'd7, 0, 32000, 21, 48, -100, -4000});
    // partner, same-ASIC hit (negative corrected time), candidate on another ASIC
    ev = {cal_hit(8'd10, 4'd2, 4000), cal_hit(8'd11, 4'd2, 4990),
          mk_hit(8'd10, 4'd2, 4'd8, 16'd3000, 8'd30, 13'h1F00), cal_hit(8'd10, 4'd2, 5000)};
    send_event(ev);
    // gaps of exactly 50 and 90 bins do not pair
    ev = {cal_hit(8'd0, 4'd0, 20000), cal_hit(8'd0, 4'd0, 19200), cal_hit(8'd0, 4'd0, 18560)};
    send_event(ev);
    // tie on the largest TDC, partner on another ASIC
    ev = {cal_hit(8'd255, 4'd15, 10000), cal_hit(8'd255, 4'd15, 10000),
          cal_hit(8'd255, 4'd14, 9000)};
    send_event(ev);
    // lone candidate
    ev = {cal_hit(8'd4, 4'd4, 7000)};
    send_event(ev);
    // two partners, the later one in load order wins
    ev = {cal_hit(8'd5, 4'd5, 7100), cal_hit(8'd5, 4'd5, 6600), cal_hit(8'd5, 4'd5, 8000)};
    send_event(ev);
    drain();

    send_idle_pct = 33;
    recv_idle_pct = 45;
    send_random_until(110);
    send_big_event(MAX_HITS);
    drain();

    apply_setting('{4'd15, 0, 65535, 0, 255, -1, -4096});
    send_idle_pct = 45;
    recv_idle_pct = 33;
    send_random_until(50);
    hold_req = 1;
    repeat (4) send_big_event(12);
    send_random_until(50);
    drain();

    // windows that nothing can pass
    apply_setting('{4'd0, 65535, 65535, 255, 255, -4096, 4095});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_until(30);
    drain();

    apply_setting('{4'd3, 2000, 6000, 30, 40, -2000, -2500});
    send_random_until(60);
    send_big_event(MAX_HITS + 1);
    send_big_event(MAX_HITS + 6);
    drain();

    $display("Sent %0d hits in %0d events under five register settings", items_sent,
             event_count);
    $display("Checked %0d results; %0d events had a reference, %0d overflowed",
             result_count, ref_count, ovf_count);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
